// ===== src/fccm_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the
// cluster chain manager. No dependencies.
package fccm_pkg;

  localparam int MAX_CLUSTERS = 1024;
  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int CW = AW + 1;

  localparam logic [CW-1:0] ENT_FREE = {1'b1, {AW{1'b0}}};
  localparam logic [CW-1:0] ENT_END  = {CW{1'b0}};
  localparam logic [10:0]   CNT_MAX  = 11'h7FF;
  localparam logic [10:0]   CC_RESET = 11'd1024;
  localparam logic [10:0]   CC_MIN   = 11'd2;
  localparam logic [10:0]   CC_MAX   = 11'(MAX_CLUSTERS);
  localparam logic [AW-1:0] IDX_LAST = AW'(MAX_CLUSTERS - 1);

  localparam logic [2:0] CMD_FORMAT  = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_FREE    = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_RECOUNT = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_LOOP    = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FMT,
    OP_SCAN,
    OP_RD_CL,
    OP_RD_CUR,
    OP_WR_PREV,
    OP_WR_NEW,
    OP_FREE_STEP,
    OP_LATCH,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       link_en;
    logic       cl_zero;
    logic       cl_ge_n;
    logic       idx_last;
    logic       hit;
    logic       scan_done;
    logic       ent_free;
    logic       ent_end;
    logic       link_ge_n;
    logic       steps_ge_n;
    logic       freed_zero;
  } dp_status_t;

endpackage

// ===== src/fccm_dp.sv =====
// Datapath: link table memory, scan and walk counters, free counter,
// configuration register and result registers. Depends on fccm_pkg.
module fccm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fccm_pkg::dp_cmd_t    dp_cmd,
  output fccm_pkg::dp_status_t dp_st,
  input  logic [2:0]           in_cmd,
  input  logic [9:0]           in_cluster,
  input  logic                 in_link_enable,
  input  logic [9:0]           in_skip_free,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [9:0]           out_cluster_out,
  output logic                 out_entry_is_free,
  output logic                 out_entry_is_end,
  output logic [10:0]          out_free_total,
  output logic [10:0]          out_freed_count
);
  import fccm_pkg::*;

  logic [CW-1:0] mem [MAX_CLUSTERS];
  logic [CW-1:0] rd_data_r;

  logic [10:0]   cc_r;
  logic [10:0]   n;
  logic [2:0]    cmd_r;
  logic [AW-1:0] cl_r, cur_r, cur_nxt, found_r, found_nxt;
  logic          link_en_r;
  logic [9:0]    left_r, left_nxt;
  logic [10:0]   idx_r, idx_nxt;
  logic [10:0]   cnt_r, cnt_nxt;
  logic [10:0]   freed_r, freed_nxt;
  logic [10:0]   free_cnt_r, free_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] ent_r;
  logic          ent_v_r;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [CW-1:0] wd;
  logic          idx_lt_n, ent_free, hit, scan_done;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [AW-1:0] out_cl_r;
  logic          out_free_r, out_end_r;
  logic [10:0]   out_total_r, out_freed_r;

  assign n = (cc_r < CC_MIN) ? CC_MIN : ((cc_r > CC_MAX) ? CC_MAX : cc_r);
  assign idx_lt_n  = idx_r < n;
  assign ent_free  = rd_data_r[CW-1];
  assign hit       = pend_r && ent_free && (left_r == '0) && (cmd_r == CMD_ALLOC);
  assign scan_done = !pend_r && !idx_lt_n;

  always_comb begin
    dp_st.cmd        = cmd_r;
    dp_st.link_en    = link_en_r;
    dp_st.cl_zero    = cl_r == '0;
    dp_st.cl_ge_n    = {1'b0, cl_r} >= n;
    dp_st.idx_last   = idx_r[AW-1:0] == IDX_LAST;
    dp_st.hit        = hit;
    dp_st.scan_done  = scan_done;
    dp_st.ent_free   = ent_free;
    dp_st.ent_end    = rd_data_r == ENT_END;
    dp_st.link_ge_n  = {1'b0, rd_data_r[AW-1:0]} >= n;
    dp_st.steps_ge_n = freed_r >= n;
    dp_st.freed_zero = freed_r == '0;
  end

  always_comb begin
    we           = 1'b0;
    wa           = cl_r;
    wd           = ENT_END;
    ra           = cl_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    left_nxt     = left_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    cur_nxt      = cur_r;
    freed_nxt    = freed_r;
    free_cnt_nxt = free_cnt_r;
    case (dp_cmd.op)
      OP_FMT: begin
        we      = 1'b1;
        wa      = idx_r[AW-1:0];
        wd      = (idx_r == '0) ? ENT_END : ENT_FREE;
        idx_nxt = idx_r + 11'd1;
        if (idx_r[AW-1:0] == IDX_LAST) free_cnt_nxt = n - 11'd1;
      end
      OP_SCAN: begin
        ra       = idx_r[AW-1:0];
        pend_nxt = idx_lt_n;
        if (idx_lt_n) idx_nxt = idx_r + 11'd1;
        if (pend_r && ent_free) begin
          cnt_nxt = cnt_r + 11'd1;
          if (hit) found_nxt = idx_r[AW-1:0] - AW'(1);
          else if (left_r != '0) left_nxt = left_r - 10'd1;
        end
        if (scan_done && (cmd_r == CMD_RECOUNT)) free_cnt_nxt = cnt_r;
      end
      OP_RD_CL:  ra = cl_r;
      OP_RD_CUR: ra = cur_r;
      OP_WR_PREV: begin
        we = 1'b1;
        wa = cl_r;
        wd = {1'b0, found_r};
        if ((cl_r != found_r) && ent_free && (free_cnt_r != '0))
          free_cnt_nxt = free_cnt_r - 11'd1;
      end
      OP_WR_NEW: begin
        we = 1'b1;
        wa = found_r;
        wd = ENT_END;
        if (free_cnt_r != '0) free_cnt_nxt = free_cnt_r - 11'd1;
      end
      OP_FREE_STEP: begin
        wa = cur_r;
        wd = ENT_FREE;
        if (!ent_free) begin
          we        = 1'b1;
          freed_nxt = freed_r + 11'd1;
          cur_nxt   = rd_data_r[AW-1:0];
          if (free_cnt_r != CNT_MAX) free_cnt_nxt = free_cnt_r + 11'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= CC_RESET;
      free_cnt_r  <= '0;
      pend_r      <= 1'b0;
      ent_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cc_r <= cfg_data;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= dp_cmd.op == OP_EMIT;
      if (dp_cmd.op == OP_LOAD) begin
        pend_r  <= 1'b0;
        ent_v_r <= 1'b0;
      end else begin
        pend_r <= pend_nxt;
        if (dp_cmd.op == OP_LATCH) ent_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_LOAD) begin
      cmd_r     <= in_cmd;
      cl_r      <= in_cluster;
      link_en_r <= in_link_enable;
      left_r    <= in_skip_free;
      idx_r     <= (in_cmd == CMD_ALLOC) ? 11'd1 : 11'd0;
      cnt_r     <= '0;
      found_r   <= '0;
      cur_r     <= in_cluster;
      freed_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      cur_r   <= cur_nxt;
      freed_r <= freed_nxt;
    end
    if (dp_cmd.op == OP_LATCH) ent_r <= rd_data_r;
    if (dp_cmd.op == OP_EMIT) begin
      out_status_r <= dp_cmd.status;
      out_cl_r     <= found_r | ((ent_v_r && !ent_r[CW-1]) ? ent_r[AW-1:0] : '0);
      out_free_r   <= ent_v_r && ent_r[CW-1];
      out_end_r    <= ent_v_r && (ent_r == ENT_END);
      out_total_r  <= free_cnt_r;
      out_freed_r  <= freed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_cluster_out   = out_cl_r;
  assign out_entry_is_free = out_free_r;
  assign out_entry_is_end  = out_end_r;
  assign out_free_total    = out_total_r;
  assign out_freed_count   = out_freed_r;

endmodule

// ===== src/fccm_ctrl.sv =====
// Controller state machine: sequences format, allocate, free chain, read
// and recount over the datapath. Depends on fccm_pkg.
module fccm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output fccm_pkg::dp_cmd_t    dp_cmd,
  input  fccm_pkg::dp_status_t dp_st
);
  import fccm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_FMT, S_ASCAN, S_APRD, S_APCHK, S_AWNEW,
    S_FRD, S_FCHK, S_RRD, S_RCHK, S_RSCAN, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    dp_cmd.op     = OP_NONE;
    dp_cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_cmd.op  = OP_LOAD;
          status_nxt = ST_OK;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (dp_st.cmd)
          CMD_FORMAT: state_nxt = S_FMT;
          CMD_ALLOC: begin
            if (dp_st.link_en && dp_st.cl_ge_n) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ASCAN;
            end
          end
          CMD_FREE: begin
            if (dp_st.cl_zero || dp_st.cl_ge_n) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FRD;
            end
          end
          CMD_READ: begin
            if (dp_st.cl_ge_n) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_RRD;
            end
          end
          CMD_RECOUNT: state_nxt = S_RSCAN;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_FMT: begin
        dp_cmd.op = OP_FMT;
        if (dp_st.idx_last) state_nxt = S_DONE;
      end
      S_ASCAN: begin
        dp_cmd.op = OP_SCAN;
        if (dp_st.hit) begin
          state_nxt = dp_st.link_en ? S_APRD : S_AWNEW;
        end else if (dp_st.scan_done) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end
      end
      S_APRD: begin
        dp_cmd.op = OP_RD_CL;
        state_nxt = S_APCHK;
      end
      S_APCHK: begin
        dp_cmd.op = OP_WR_PREV;
        state_nxt = S_AWNEW;
      end
      S_AWNEW: begin
        dp_cmd.op = OP_WR_NEW;
        state_nxt = S_DONE;
      end
      S_FRD: begin
        if (dp_st.steps_ge_n) begin
          status_nxt = ST_LOOP;
          state_nxt  = S_DONE;
        end else begin
          dp_cmd.op = OP_RD_CUR;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        dp_cmd.op = OP_FREE_STEP;
        if (dp_st.ent_free) begin
          status_nxt = dp_st.freed_zero ? ST_OK : ST_LOOP;
          state_nxt  = S_DONE;
        end else if (dp_st.ent_end) begin
          state_nxt = S_DONE;
        end else if (dp_st.link_ge_n) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_RRD: begin
        dp_cmd.op = OP_RD_CL;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        dp_cmd.op = OP_LATCH;
        state_nxt = S_DONE;
      end
      S_RSCAN: begin
        dp_cmd.op = OP_SCAN;
        if (dp_st.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        dp_cmd.op = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== src/fat_cluster_chain_manager_core.sv =====
// Cluster chain manager top level: controller plus datapath. Format writes every table
// entry; allocate scans up to n entries, recount the first n; free chain reads and then
// frees each entry it visits, at most n (n = clamped cluster count). One command at a time:
// the table walk, one entry a cycle (a read and a free step per link for free chain), sets
// throughput; the receiver cannot stall. Synchronous reset clears control and free count,
// sets the cluster count to 1024 and leaves the table undefined until a format command.
module fat_cluster_chain_manager_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [9:0]  in_cluster,
  input  logic        in_link_enable,
  input  logic [9:0]  in_skip_free,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [9:0]  out_cluster_out,
  output logic        out_entry_is_free,
  output logic        out_entry_is_end,
  output logic [10:0] out_free_total,
  output logic [10:0] out_freed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import fccm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;

  assign cfg_ready = 1'b1;

  fccm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .dp_cmd (dp_cmd),
    .dp_st  (dp_st)
  );

  fccm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .dp_st             (dp_st),
    .in_cmd            (in_cmd),
    .in_cluster        (in_cluster),
    .in_link_enable    (in_link_enable),
    .in_skip_free      (in_skip_free),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_cluster_out   (out_cluster_out),
    .out_entry_is_free (out_entry_is_free),
    .out_entry_is_end  (out_entry_is_end),
    .out_free_total    (out_free_total),
    .out_freed_count   (out_freed_count)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for fat_cluster_chain_manager_core: directed steps, then random
// command streams built around allocated chains. Depends on fccm_pkg and the core.
// Each beat is checked field by field against the in-bench model or a typed outcome.
`timescale 1ns / 1ps
module tb;
  import fccm_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS   = 555;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int SETTLE_CYCLES  = 20;

  typedef enum logic [1:0] {SLOT_FREE, SLOT_END, SLOT_LINK} slot_kind_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  link;
    logic        is_free;
    logic        is_end;
    logic [10:0] total;
    logic [10:0] freed;
  } outcome_t;

  typedef struct {
    bit          is_cfg;
    logic [10:0] cfg;
    logic [2:0]  cmd;
    logic [9:0]  cl;
    logic        lk;
    logic [9:0]  skip;
    bit          typed;
    outcome_t    want;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [9:0]  in_cluster;
  logic        in_link_enable;
  logic [9:0]  in_skip_free;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [9:0]  out_cluster_out;
  logic        out_entry_is_free;
  logic        out_entry_is_end;
  logic [10:0] out_free_total;
  logic [10:0] out_freed_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  fat_cluster_chain_manager_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_cluster        (in_cluster),
    .in_link_enable    (in_link_enable),
    .in_skip_free      (in_skip_free),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_cluster_out   (out_cluster_out),
    .out_entry_is_free (out_entry_is_free),
    .out_entry_is_end  (out_entry_is_end),
    .out_free_total    (out_free_total),
    .out_freed_count   (out_freed_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  slot_kind_t  slot_kind [MAX_CLUSTERS];
  logic [9:0]  slot_next [MAX_CLUSTERS];
  logic [10:0] free_cnt;
  logic [10:0] count_reg;

  outcome_t pending_results [$];
  outcome_t last_outcome;
  step_t    directed_steps [$];
  bit       typed_flag;
  outcome_t typed_want;
  int       beats_taken;
  int       cfg_writes;
  int       errors;
  int       idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int clamp_count(input logic [10:0] v);
    if (v < CC_MIN) return CC_MIN;
    if (v > CC_MAX) return CC_MAX;
    return v;
  endfunction

  function automatic outcome_t apply_command(input logic [2:0] cmd, input logic [9:0] cl,
                                             input logic lk, input logic [9:0] skip);
    outcome_t   r;
    int         n;
    int         i;
    int         left;
    int         found;
    int         cur;
    int         steps;
    int         freed;
    int         cnt;
    bit         hit;
    bit         stop;
    slot_kind_t kind;
    logic [9:0] nxt;
    r = '0;
    n = clamp_count(count_reg);
    freed = 0;
    case (cmd)
      CMD_FORMAT: begin
        for (i = 0; i < MAX_CLUSTERS; i++) slot_kind[i] = (i == 0) ? SLOT_END : SLOT_FREE;
        free_cnt = 11'(n - 1);
      end
      CMD_ALLOC: begin
        if (lk && cl >= n) begin
          r.status = ST_RANGE;
        end else begin
          left = skip;
          hit = 1'b0;
          found = 0;
          for (i = 1; i < n && !hit; i++) begin
            if (slot_kind[i] == SLOT_FREE) begin
              if (left == 0) begin
                found = i;
                hit = 1'b1;
              end else begin
                left--;
              end
            end
          end
          if (!hit) begin
            r.status = ST_NOSPACE;
          end else begin
            if (lk) begin
              if (cl != found && slot_kind[cl] == SLOT_FREE && free_cnt != 0) free_cnt--;
              slot_kind[cl] = SLOT_LINK;
              slot_next[cl] = 10'(found);
            end
            slot_kind[found] = SLOT_END;
            if (free_cnt != 0) free_cnt--;
            r.link = 10'(found);
          end
        end
      end
      CMD_FREE: begin
        if (cl == 0 || cl >= n) begin
          r.status = ST_RANGE;
        end else begin
          cur = cl;
          steps = 0;
          stop = 1'b0;
          while (!stop) begin
            if (steps >= n) begin
              r.status = ST_LOOP;
              stop = 1'b1;
            end else if (slot_kind[cur] == SLOT_FREE) begin
              if (freed != 0) r.status = ST_LOOP;
              stop = 1'b1;
            end else begin
              kind = slot_kind[cur];
              nxt = slot_next[cur];
              slot_kind[cur] = SLOT_FREE;
              if (free_cnt != CNT_MAX) free_cnt++;
              freed++;
              steps++;
              if (kind == SLOT_END) begin
                stop = 1'b1;
              end else if (nxt >= n) begin
                r.status = ST_RANGE;
                stop = 1'b1;
              end else begin
                cur = nxt;
              end
            end
          end
          r.freed = 11'(freed);
        end
      end
      CMD_READ: begin
        if (cl >= n) begin
          r.status = ST_RANGE;
        end else begin
          case (slot_kind[cl])
            SLOT_FREE: r.is_free = 1'b1;
            SLOT_END:  r.is_end = 1'b1;
            default:   r.link = slot_next[cl];
          endcase
        end
      end
      CMD_RECOUNT: begin
        cnt = 0;
        for (i = 0; i < n; i++) if (slot_kind[i] == SLOT_FREE) cnt++;
        free_cnt = (cnt > CNT_MAX) ? CNT_MAX : 11'(cnt);
      end
      default: ;
    endcase
    r.total = free_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t predicted;
    if (rst_n) begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, status %0d", $time, out_status);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("cluster_out", want.link, out_cluster_out);
          check_field("entry_is_free", want.is_free, out_entry_is_free);
          check_field("entry_is_end", want.is_end, out_entry_is_end);
          check_field("free_total", want.total, out_free_total);
          check_field("freed_count", want.freed, out_freed_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        count_reg = cfg_data;
        cfg_writes++;
      end
      if (start && !busy) begin
        idle_cycles = 0;
        predicted = apply_command(in_cmd, in_cluster, in_link_enable, in_skip_free);
        last_outcome = predicted;
        pending_results.push_back(typed_flag ? typed_want : predicted);
        beats_taken++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [2:0] cmd, input logic [9:0] cl, input logic lk,
                           input logic [9:0] skip, input bit typed, input outcome_t want);
    int target;
    in_cmd         <= cmd;
    in_cluster     <= cl;
    in_link_enable <= lk;
    in_skip_free   <= skip;
    typed_flag     <= typed;
    typed_want     <= want;
    start          <= 1'b1;
    target = beats_taken + 1;
    do @(negedge clk); while (beats_taken != target);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_count(input logic [10:0] v);
    int target;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    target = cfg_writes + 1;
    do @(negedge clk); while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic idle_for(input int k);
    start <= 1'b0;
    repeat (k) @(negedge clk);
  endtask

  function automatic void add_cfg(input logic [10:0] v);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg = v;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_cmd(input logic [2:0] cmd, input logic [9:0] cl, input logic lk,
                                  input logic [9:0] skip);
    step_t s;
    s = '{default: '0};
    s.cmd = cmd;
    s.cl = cl;
    s.lk = lk;
    s.skip = skip;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_typed(input logic [2:0] cmd, input logic [9:0] cl, input logic lk,
                                    input logic [9:0] skip, input logic [1:0] status,
                                    input logic [9:0] link, input logic fr, input logic en,
                                    input logic [10:0] total);
    step_t s;
    s = '{default: '0};
    s.cmd = cmd;
    s.cl = cl;
    s.lk = lk;
    s.skip = skip;
    s.typed = 1'b1;
    s.want = '{status, link, fr, en, total, 11'd0};
    directed_steps.push_back(s);
  endfunction

  initial begin : stimulus
    step_t       st;
    int          roll;
    int          sub;
    int          items_sent;
    int          phase;
    int          phase_len;
    int          k;
    int          burst_left;
    int          n_eff;
    bit          chain_open;
    logic [9:0]  head;
    logic [9:0]  tail;
    logic [2:0]  c_cmd;
    logic [9:0]  c_cl;
    logic        c_lk;
    logic [9:0]  c_skip;
    logic [10:0] cfg_pick;

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_cluster = '0;
    in_link_enable = 1'b0;
    in_skip_free = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    typed_flag = 1'b0;
    typed_want = '0;
    beats_taken = 0;
    cfg_writes = 0;
    errors = 0;
    idle_cycles = 0;
    free_cnt = '0;
    count_reg = CC_RESET;
    last_outcome = '0;
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      slot_kind[i] = SLOT_END;
      slot_next[i] = '0;
    end

    add_typed(CMD_SPARE_HI, 10'd0, 1'b0, 10'd0, ST_OK, 10'd0, 1'b0, 1'b0, 11'd0);
    add_typed(CMD_FORMAT, 10'd0, 1'b0, 10'd0, ST_OK, 10'd0, 1'b0, 1'b0, 11'd1023);
    add_typed(CMD_READ, 10'd0, 1'b0, 10'd0, ST_OK, 10'd0, 1'b0, 1'b1, 11'd1023);
    add_typed(CMD_READ, 10'd1023, 1'b0, 10'd0, ST_OK, 10'd0, 1'b1, 1'b0, 11'd1023);
    add_typed(CMD_ALLOC, 10'd1023, 1'b0, 10'd0, ST_OK, 10'd1, 1'b0, 1'b0, 11'd1022);
    add_typed(CMD_ALLOC, 10'd0, 1'b0, 10'd1022, ST_NOSPACE, 10'd0, 1'b0, 1'b0, 11'd1022);
    add_typed(CMD_ALLOC, 10'd1, 1'b1, 10'd1021, ST_OK, 10'd1023, 1'b0, 1'b0, 11'd1021);
    add_cmd(CMD_READ, 10'd1, 1'b0, 10'd0);
    add_cmd(CMD_ALLOC, 10'd1023, 1'b1, 10'd0);
    add_cmd(CMD_ALLOC, 10'd5, 1'b1, 10'd0);
    add_cmd(CMD_ALLOC, 10'd4, 1'b1, 10'd0);
    add_cmd(CMD_FREE, 10'd0, 1'b0, 10'd0);
    add_cmd(CMD_FREE, 10'd1, 1'b0, 10'd0);
    add_cmd(CMD_FREE, 10'd1, 1'b0, 10'd0);
    add_cmd(CMD_FREE, 10'd5, 1'b0, 10'd0);
    add_cfg(11'd0);
    add_typed(CMD_FORMAT, 10'd0, 1'b0, 10'd0, ST_OK, 10'd0, 1'b0, 1'b0, 11'd1);
    add_typed(CMD_READ, 10'd2, 1'b0, 10'd0, ST_RANGE, 10'd0, 1'b0, 1'b0, 11'd1);
    add_typed(CMD_ALLOC, 10'd2, 1'b1, 10'd0, ST_RANGE, 10'd0, 1'b0, 1'b0, 11'd1);
    add_typed(CMD_ALLOC, 10'd0, 1'b0, 10'd0, ST_OK, 10'd1, 1'b0, 1'b0, 11'd0);
    add_cfg(11'd8);
    add_cmd(CMD_ALLOC, 10'd1, 1'b1, 10'd0);
    add_cmd(CMD_ALLOC, 10'd2, 1'b1, 10'd0);
    add_cfg(11'd3);
    add_cmd(CMD_FREE, 10'd1, 1'b0, 10'd0);
    add_cfg(11'd2047);
    add_cmd(CMD_ALLOC, 10'd3, 1'b1, 10'd0);
    add_cmd(CMD_FREE, 10'd1, 1'b0, 10'd0);
    add_cmd(CMD_FREE, 10'd3, 1'b0, 10'd0);
    add_cmd(CMD_RECOUNT, 10'd0, 1'b0, 10'd0);
    add_cmd(CMD_SPARE_LO, 10'd0, 1'b0, 10'd0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.is_cfg) begin
        wait_drained();
        write_count(st.cfg);
      end else begin
        send_beat(st.cmd, st.cl, st.lk, st.skip, st.typed, st.want);
      end
    end

    items_sent = 0;
    phase = 0;
    burst_left = $urandom_range(1, 8);
    head = '0;
    tail = '0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0: cfg_pick = 11'd1;
        1: cfg_pick = 11'd2;
        2: cfg_pick = 11'd1024;
        3: cfg_pick = 11'd2047;
        default: cfg_pick = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                                        : 11'($urandom_range(3, 40));
      endcase
      phase++;
      wait_drained();
      write_count(cfg_pick);
      n_eff = clamp_count(cfg_pick);
      chain_open = 1'b0;
      phase_len = (n_eff > 64) ? 12 : 40;
      if ($urandom_range(0, 1) == 1) begin
        send_beat(CMD_FORMAT, '0, 1'b0, '0, 1'b0, '0);
        items_sent++;
      end
      for (k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        c_cl = '0;
        c_lk = 1'b0;
        c_skip = '0;
        if (roll < 35) begin
          c_cmd = CMD_ALLOC;
          c_lk = chain_open;
          c_cl = chain_open ? tail : 10'($urandom_range(0, 1023));
          if ($urandom_range(0, 3) == 0) c_skip = 10'($urandom_range(0, n_eff - 1));
        end else if (roll < 50) begin
          c_cmd = CMD_FREE;
          c_cl = (chain_open && $urandom_range(0, 3) != 0) ? head
                                                          : 10'($urandom_range(0, n_eff - 1));
        end else if (roll < 65) begin
          c_cmd = CMD_READ;
          sub = $urandom_range(0, 3);
          if (chain_open && sub == 0) c_cl = tail;
          else if (chain_open && sub == 1) c_cl = head;
          else if (sub == 3) c_cl = 10'($urandom_range(0, 1023));
          else c_cl = 10'($urandom_range(0, n_eff - 1));
        end else if (roll < 70) begin
          c_cmd = CMD_RECOUNT;
        end else if (roll < 72) begin
          c_cmd = CMD_FORMAT;
        end else if (roll < 76) begin
          c_cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          c_cl = 10'($urandom_range(0, 1023));
        end else begin
          c_cmd = 3'($urandom_range(0, 7));
          c_cl = 10'($urandom_range(0, 1023));
          c_lk = 1'($urandom_range(0, 1));
          c_skip = 10'($urandom_range(0, 1023));
        end
        send_beat(c_cmd, c_cl, c_lk, c_skip, 1'b0, '0);
        items_sent++;

        if (c_cmd == CMD_ALLOC && last_outcome.status == ST_OK) begin
          if (c_lk && chain_open && c_cl == tail) begin
            tail = last_outcome.link;
          end else if (!c_lk) begin
            head = last_outcome.link;
            tail = head;
            chain_open = 1'b1;
          end
        end
        if ((c_cmd == CMD_FREE && c_cl == head) || c_cmd == CMD_FORMAT) chain_open = 1'b0;

        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 5) == 0) wait_drained();
          else idle_for($urandom_range(1, 12));
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fccm_pkg.sv
src/fccm_dp.sv
src/fccm_ctrl.sv
src/fat_cluster_chain_manager_core.sv
test/tb.sv
